// ===== design/kvt_pkg.sv =====
// Shared types and constants for the key/value table.
package kvt_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 16;
    localparam int VALUE_BITS = 16;
    localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Request codes; code 3 is unused and changes nothing
    typedef enum logic [1:0] {
        OP_PUT    = 2'd0,
        OP_GET    = 2'd1,
        OP_REMOVE = 2'd2
    } kvt_op_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } kvt_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_req;
        logic execute;
    } kvt_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_blocked;
    } kvt_stat_t;

endpackage

// ===== design/kvt_ctrl.sv =====
// Sequencer for the key/value table: accepts a word, then runs the lookup and update.
module kvt_ctrl
    import kvt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  kvt_stat_t stat_i,
    output kvt_cmd_t  cmd_o
);

    kvt_state_t state_reg;
    kvt_state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next       = state_reg;
        cmd_o.load_req   = 1'b0;
        cmd_o.execute    = 1'b0;
        s_ready          = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_o.load_req = 1'b1;
                    state_next     = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // hold until the result register can take the new word
                if (!stat_i.out_blocked) begin
                    cmd_o.execute = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/kvt_datapath.sv =====
// Entry storage, parallel key compare, slot pick and result register.
module kvt_datapath
    import kvt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  kvt_cmd_t              cmd_i,
    output kvt_stat_t             stat_o,
    input  logic [1:0]            s_req_type,
    input  logic [KEY_BITS-1:0]   s_req_key,
    input  logic [VALUE_BITS-1:0] s_req_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [VALUE_BITS-1:0] m_read_value,
    output logic                  m_hit,
    output logic                  m_table_full
);

    // Request held for the execute cycle
    logic [1:0]            req_type_reg;
    logic [KEY_BITS-1:0]   req_key_reg;
    logic [VALUE_BITS-1:0] req_value_reg;

    // Entry cells
    logic [KEY_BITS-1:0]   entry_keys_reg   [ENTRIES];
    logic [VALUE_BITS-1:0] entry_values_reg [ENTRIES];
    logic [ENTRIES-1:0]    entry_valid_reg;

    // Result register
    logic                  out_valid_reg;
    logic [VALUE_BITS-1:0] out_value_reg;
    logic                  out_hit_reg;
    logic                  out_full_reg;

    // Lookup results
    logic [ENTRIES-1:0]    match_vec;
    logic                  hit_any;
    logic                  free_any;
    logic [IDX_BITS-1:0]   match_idx;
    logic [IDX_BITS-1:0]   free_idx;

    // Capture the request word
    always_ff @(posedge aclk) begin
        if (cmd_i.load_req) begin
            req_type_reg  <= s_req_type;
            req_key_reg   <= s_req_key;
            req_value_reg <= s_req_value;
        end
    end

    // Compare the key against every cell at once
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match_vec[i] = entry_valid_reg[i] && (entry_keys_reg[i] == req_key_reg);
        end
    end

    assign hit_any  = |match_vec;
    assign free_any = ~(&entry_valid_reg);

    // Lowest matching cell and lowest free cell
    always_comb begin
        match_idx = '0;
        free_idx  = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (match_vec[i]) begin
                match_idx = IDX_BITS'(i);
            end
            if (!entry_valid_reg[i]) begin
                free_idx = IDX_BITS'(i);
            end
        end
    end

    // Table update: valid marks
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
        end else if (cmd_i.execute) begin
            unique case (kvt_op_t'(req_type_reg))
                OP_PUT: begin
                    if (!hit_any && free_any) begin
                        entry_valid_reg[free_idx] <= 1'b1;
                    end
                end
                OP_REMOVE: begin
                    entry_valid_reg <= entry_valid_reg & ~match_vec;
                end
                default: begin
                end
            endcase
        end
    end

    // Table update: keys and values
    always_ff @(posedge aclk) begin
        if (cmd_i.execute && (kvt_op_t'(req_type_reg) == OP_PUT)) begin
            if (hit_any) begin
                entry_values_reg[match_idx] <= req_value_reg;
            end else if (free_any) begin
                entry_keys_reg[free_idx]   <= req_key_reg;
                entry_values_reg[free_idx] <= req_value_reg;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (cmd_i.execute) begin
            out_value_reg <= '0;
            out_hit_reg   <= 1'b0;
            out_full_reg  <= 1'b0;
            unique case (kvt_op_t'(req_type_reg))
                OP_PUT: begin
                    out_hit_reg  <= hit_any;
                    out_full_reg <= !hit_any && !free_any;
                end
                OP_GET: begin
                    out_hit_reg <= hit_any;
                    if (hit_any) begin
                        out_value_reg <= entry_values_reg[match_idx];
                    end
                end
                OP_REMOVE: begin
                    out_hit_reg <= hit_any;
                end
                default: begin
                end
            endcase
        end
    end

    // Result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd_i.execute) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign stat_o.out_blocked = out_valid_reg && !m_ready;

    assign m_valid      = out_valid_reg;
    assign m_read_value = out_value_reg;
    assign m_hit        = out_hit_reg;
    assign m_table_full = out_full_reg;

endmodule

// ===== design/key_value_table.sv =====
// Key/value table: 16-entry associative store with put, get and remove.
// A word is accepted in the idle step; its result is registered in the execute step,
// which waits while the previous result is still waiting to be taken.
// No new word is accepted until the current one has been executed.
// Reset (synchronous, active low) clears all valid marks and the result flag.
module key_value_table
    import kvt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_req_type,
    input  logic [KEY_BITS-1:0]   s_req_key,
    input  logic [VALUE_BITS-1:0] s_req_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [VALUE_BITS-1:0] m_read_value,
    output logic                  m_hit,
    output logic                  m_table_full
);

    kvt_cmd_t  cmd;
    kvt_stat_t stat;

    kvt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat_i  (stat),
        .cmd_o   (cmd)
    );

    kvt_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_i        (cmd),
        .stat_o       (stat),
        .s_req_type   (s_req_type),
        .s_req_key    (s_req_key),
        .s_req_value  (s_req_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_hit        (m_hit),
        .m_table_full (m_table_full)
    );

    // Never overwrite a result that is still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.execute |-> !(m_valid && !m_ready))
        else $error("result overwritten while stalled");

    // One word in flight: no accept right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second word accepted during execute");

    // A dropped put never also reports a hit
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_table_full) |-> !m_hit)
        else $error("table_full together with hit");

    // A miss always returns zero data
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_hit) |-> (m_read_value == '0))
        else $error("nonzero value on a miss");

endmodule

// ===== tb/key_value_table_tb.sv =====
// Self-checking testbench for the key/value table: directed and random put/get/remove traffic.
`timescale 1ns / 100ps

module key_value_table_tb;
    import kvt_pkg::*;

    // Request code 3 is not decoded by the table
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int         STALL_LIMIT = 5000;
    localparam int         KEY_POOL_SIZE = 24;

    typedef struct {
        logic [1:0]            op;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } kv_request_t;

    typedef struct {
        logic [VALUE_BITS-1:0] read_value;
        logic                  hit;
        logic                  table_full;
    } kv_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_req_type = '0;
    logic [KEY_BITS-1:0]   s_req_key = '0;
    logic [VALUE_BITS-1:0] s_req_value = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [VALUE_BITS-1:0] m_read_value;
    logic                  m_hit;
    logic                  m_table_full;

    // Shadow copy of the table contents
    logic [KEY_BITS-1:0]   shadow_keys   [ENTRIES];
    logic [VALUE_BITS-1:0] shadow_values [ENTRIES];
    logic                  shadow_valid  [ENTRIES];

    kv_request_t request_queue[$];
    kv_result_t  pending_results[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    logic        hold_sender = 1'b1;

    int error_count    = 0;
    int accepted_count = 0;
    int result_count   = 0;
    int hit_count      = 0;
    int full_count     = 0;
    int idle_cycles    = 0;

    logic [KEY_BITS-1:0] key_pool[KEY_POOL_SIZE];

    key_value_table u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_req_key    (s_req_key),
        .s_req_value  (s_req_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_hit        (m_hit),
        .m_table_full (m_table_full)
    );

    always #2 aclk = ~aclk;

    // Apply one request to the shadow table and return the result it should give
    function automatic kv_result_t table_access(kv_request_t req);
        kv_result_t res;
        int         slot;
        res  = '{read_value: '0, hit: 1'b0, table_full: 1'b0};
        slot = -1;
        case (req.op)
            OP_PUT: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (slot < 0 && shadow_valid[i] && shadow_keys[i] == req.key) slot = i;
                end
                if (slot >= 0) begin
                    shadow_values[slot] = req.value;
                    res.hit = 1'b1;
                end else begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (slot < 0 && !shadow_valid[i]) slot = i;
                    end
                    if (slot >= 0) begin
                        shadow_keys[slot]   = req.key;
                        shadow_values[slot] = req.value;
                        shadow_valid[slot]  = 1'b1;
                    end else begin
                        res.table_full = 1'b1;
                    end
                end
            end
            OP_GET: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (slot < 0 && shadow_valid[i] && shadow_keys[i] == req.key) slot = i;
                end
                if (slot >= 0) begin
                    res.read_value = shadow_values[slot];
                    res.hit        = 1'b1;
                end
            end
            OP_REMOVE: begin
                // every matching entry goes, though a put never makes duplicates
                for (int i = 0; i < ENTRIES; i++) begin
                    if (shadow_valid[i] && shadow_keys[i] == req.key) begin
                        shadow_valid[i] = 1'b0;
                        res.hit         = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Request driver: predicts on acceptance, then loads the next word
    always @(posedge aclk) begin : drive_requests
        kv_request_t nxt;
        kv_request_t cur;
        logic        load;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                cur.op    = s_req_type;
                cur.key   = s_req_key;
                cur.value = s_req_value;
                pending_results.insert(pending_results.size(), table_access(cur));
                accepted_count++;
            end
            if (!s_valid || s_ready) begin
                load = (request_queue.size() != 0) && !hold_sender &&
                       ($urandom_range(99) >= send_idle_pct);
                if (load) begin
                    nxt = request_queue.pop_front();
                    s_req_type  <= nxt.op;
                    s_req_key   <= nxt.key;
                    s_req_value <= nxt.value;
                end
                s_valid <= load;
            end
        end
    end

    // Receiver back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result monitor
    always @(posedge aclk) begin : check_results
        kv_result_t want;
        if (aresetn && m_valid && m_ready) begin
            result_count++;
            if (m_hit) hit_count++;
            if (m_table_full) full_count++;
            if (pending_results.size() == 0) begin
                $error("unexpected result word: read_value %h hit %b table_full %b",
                       m_read_value, m_hit, m_table_full);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_read_value !== want.read_value) begin
                    $error("read_value: expected %h, got %h", want.read_value, m_read_value);
                    error_count++;
                end
                if (m_hit !== want.hit) begin
                    $error("hit: expected %b, got %b", want.hit, m_hit);
                    error_count++;
                end
                if (m_table_full !== want.table_full) begin
                    $error("table_full: expected %b, got %b", want.table_full, m_table_full);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("Timeout after %0d cycles without a handshake", idle_cycles);
                $display("Regression FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic add_request(logic [1:0] op, logic [KEY_BITS-1:0] key,
                               logic [VALUE_BITS-1:0] value);
        kv_request_t req;
        req.op    = op;
        req.key   = key;
        req.value = value;
        request_queue.insert(request_queue.size(), req);
    endtask

    // Release the sender until the queue has gone out, then hold it until every result is back
    task automatic drain_all();
        hold_sender = 1'b0;
        while (request_queue.size() != 0 || s_valid) @(posedge aclk);
        hold_sender = 1'b1;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Bursts over a small key pool so the table fills, hits and empties again
    task automatic add_random_traffic(int count);
        int          queued;
        int          burst_len;
        int unsigned put_pct;
        int unsigned pick;
        logic [1:0]  op;
        logic [KEY_BITS-1:0] key;
        queued = 0;
        while (queued < count) begin
            burst_len = $urandom_range(40, 15);
            put_pct   = $urandom_range(65, 15);
            for (int n = 0; n < burst_len && queued < count; n++) begin
                pick = $urandom_range(99);
                if (pick < put_pct)            op = OP_PUT;
                else if (pick < put_pct + 20)  op = OP_GET;
                else if (pick < 96)            op = OP_REMOVE;
                else                           op = OP_UNUSED;
                if ($urandom_range(99) < 88) key = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
                else                         key = KEY_BITS'($urandom);
                add_request(op, key, VALUE_BITS'($urandom));
                queued++;
            end
        end
    endtask

    task automatic refresh_key_pool(int count);
        for (int n = 0; n < count; n++) begin
            key_pool[$urandom_range(KEY_POOL_SIZE - 1)] = KEY_BITS'($urandom);
        end
    endtask

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            shadow_keys[i]   = '0;
            shadow_values[i] = '0;
            shadow_valid[i]  = 1'b0;
        end
        for (int i = 0; i < KEY_POOL_SIZE; i++) key_pool[i] = KEY_BITS'($urandom);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: field extremes, misses, overwrite, unused code, full table
        send_idle_pct = 24;
        recv_idle_pct = 63;
        add_request(OP_PUT,    16'h0000, 16'h0000);
        add_request(OP_PUT,    16'hFFFF, 16'hFFFF);
        add_request(OP_GET,    16'h0000, 16'hFFFF);
        add_request(OP_GET,    16'hFFFF, 16'h0000);
        add_request(OP_GET,    16'h1234, 16'h0000);
        add_request(OP_REMOVE, 16'h1234, 16'h0000);
        add_request(OP_PUT,    16'h0000, 16'hA5A5);
        add_request(OP_UNUSED, 16'hFFFF, 16'hFFFF);
        for (int i = 0; i < ENTRIES - 2; i++) begin
            add_request(OP_PUT, KEY_BITS'(1) << i, VALUE_BITS'(16'h0100 + i));
        end
        add_request(OP_PUT,    16'h8000, 16'h5A5A);
        add_request(OP_PUT,    16'h0004, 16'hC3C3);
        add_request(OP_REMOVE, 16'hFFFF, 16'h0000);
        add_request(OP_PUT,    16'h8000, 16'h5A5A);
        add_request(OP_GET,    16'h8000, 16'h0000);
        add_request(OP_GET,    16'h0004, 16'h0000);
        drain_all();

        // Random phase one: sender sparse gaps, receiver stalls often
        add_random_traffic(160);
        drain_all();

        // Random phase two: roles swapped
        send_idle_pct = 63;
        recv_idle_pct = 24;
        refresh_key_pool(6);
        add_random_traffic(160);
        drain_all();

        // Random phase three: full rate both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        refresh_key_pool(6);
        add_random_traffic(160);
        drain_all();

        repeat (10) @(posedge aclk);
        $display("Sent %0d requests, checked %0d results", accepted_count, result_count);
        $display("Results with key present: %0d, puts dropped on a full table: %0d",
                 hit_count, full_count);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
